### rtl/core/apbm_pkg.sv
// Shared blend mode codes and pipeline control types for the ARGB pixel blender.
package apbm_pkg;

  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_ADD      = 3'd1;
  localparam logic [2:0] MODE_SUBTRACT = 3'd2;
  localparam logic [2:0] MODE_MULTIPLY = 3'd3;
  localparam logic [2:0] MODE_SCREEN   = 3'd4;
  localparam logic [2:0] MODE_OVERLAY  = 3'd5;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } ctl_t;

endpackage

### rtl/core/apbm_chan.sv
// Four-stage blend datapath for one 8-bit color channel.
module apbm_chan (
  input  logic            clk,
  input  apbm_pkg::ctl_t  ctl,
  input  logic [2:0]      mode,
  input  logic [7:0]      src,
  input  logic [7:0]      dst,
  input  logic [8:0]      sa,
  output logic [7:0]      res
);

  // Stage 1 registers: raw products
  logic [7:0]  s1_r, d1_r;
  logic [8:0]  sa1_r;
  logic [16:0] ps1_r;
  logic [15:0] pm1_r;
  logic [15:0] po1_r;
  logic        hi1_r;

  // Stage 2 registers: mode result
  logic [7:0]  m2_r, d2_r;
  logic [8:0]  sa2_r;
  logic        byp2_r;

  // Stage 3 registers: weighted sum
  logic [15:0] acc3_r;
  logic [7:0]  m3_r;
  logic        byp3_r;

  // Stage 4 register: channel result
  logic [7:0]  res4_r;

  logic [16:0] ps_nxt;
  logic [15:0] pm_nxt;
  logic [15:0] po_nxt;
  logic        hi_nxt;

  logic [7:0]  ps8;
  logic [8:0]  add_sum;
  logic [7:0]  add_res;
  logic [7:0]  sub_res;
  logic [7:0]  mul_res;
  logic [8:0]  scr_sum;
  logic [15:0] ovl_inv;
  logic [7:0]  ovl_res;
  logic [7:0]  m_nxt;
  logic        byp_nxt;

  logic [15:0] acc_nxt;

  // Form the scaled source, the product term and the overlay product
  always_comb begin
    hi_nxt = dst[7];
    ps_nxt = 17'(src) * 17'(sa);
    pm_nxt = 16'(src) * (16'(dst) + 16'd1);
    if (hi_nxt) begin
      po_nxt = (16'd256 - 16'(src)) * (16'd255 - 16'(dst));
    end else begin
      po_nxt = 16'(dst) * (16'(src) + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      s1_r  <= src;
      d1_r  <= dst;
      sa1_r <= sa;
      ps1_r <= ps_nxt;
      pm1_r <= pm_nxt;
      po1_r <= po_nxt;
      hi1_r <= hi_nxt;
    end
  end

  // Pick the mode result; add and subtract skip the destination weighting
  always_comb begin
    ps8     = ps1_r[15:8];
    add_sum = 9'(d1_r) + 9'(ps8);
    add_res = add_sum[8] ? 8'hFF : add_sum[7:0];
    sub_res = (d1_r > ps8) ? (d1_r - ps8) : 8'd0;
    mul_res = pm1_r[15:8];
    scr_sum = 9'(d1_r) + 9'(s1_r) - 9'(mul_res);
    ovl_inv = 16'd32640 - po1_r;
    ovl_res = hi1_r ? ovl_inv[14:7] : po1_r[14:7];
    byp_nxt = 1'b0;
    case (mode)
      apbm_pkg::MODE_ADD: begin
        m_nxt   = add_res;
        byp_nxt = 1'b1;
      end
      apbm_pkg::MODE_SUBTRACT: begin
        m_nxt   = sub_res;
        byp_nxt = 1'b1;
      end
      apbm_pkg::MODE_MULTIPLY: m_nxt = mul_res;
      apbm_pkg::MODE_SCREEN:   m_nxt = scr_sum[7:0];
      apbm_pkg::MODE_OVERLAY:  m_nxt = ovl_res;
      default:                 m_nxt = s1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      m2_r   <= m_nxt;
      d2_r   <= d1_r;
      sa2_r  <= sa1_r;
      byp2_r <= byp_nxt;
    end
  end

  // Weight the mode result against the destination
  assign acc_nxt = 16'(d2_r) * (16'd256 - 16'(sa2_r)) + 16'(m2_r) * 16'(sa2_r);

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      acc3_r <= acc_nxt;
      m3_r   <= m2_r;
      byp3_r <= byp2_r;
    end
  end

  // Drop the fraction or pass the saturated value
  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      res4_r <= byp3_r ? m3_r : acc3_r[15:8];
    end
  end

  assign res = res4_r;

endmodule

### rtl/core/argb_pixel_blend_modes.sv
// Top level of the ARGB8888 pixel blender with six blend modes.
//
// Blends one source and one destination ARGB8888 pixel into one result pixel
// under the mode held in the configuration register (0 normal, 1 saturating
// add, 2 saturating subtract, 3 multiply, 4 screen, 5 overlay; 6 and 7 act as
// normal). The source alpha is scaled to a weight of 0..256 (plus one from 127
// up), and the result alpha is the sum of both alphas pinned at 255. The block
// takes one pixel every clock cycle while the output is not stalled; each pixel
// passes through the products, mode select, weighting multiply and output
// register stages, and stalls from the output side fill bubbles before holding
// the input. Write the mode only while no pixel is in flight.
module argb_pixel_blend_modes (
  input  logic        clk,
  input  logic        rst_n,
  // Source and destination pixels
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] src_pixel, [63:32] dst_pixel
  // Blended pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] out_pixel
  // Mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // blend_mode
);

  logic [2:0] mode_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  apbm_pkg::ctl_t ctl;

  logic [31:0] src, dst;
  logic [7:0]  src_a;
  logic [8:0]  sa;
  logic [8:0]  a_sum;
  logic [7:0]  a_nxt;
  logic [7:0]  a1_r, a2_r, a3_r, a4_r;

  logic [7:0] res_r, res_g, res_b;

  assign src   = in_tdata[31:0];
  assign dst   = in_tdata[63:32];
  assign src_a = src[31:24];
  assign sa    = 9'(src_a) + ((src_a >= 8'h7F) ? 9'd1 : 9'd0);

  // Hold the mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= apbm_pkg::MODE_NORMAL;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // Advance each stage when it is empty or the next one moves
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign ctl       = '{en1: rdy1, en2: rdy2, en3: rdy3, en4: rdy4};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Carry the saturated alpha alongside the color stages
  assign a_sum = 9'(dst[31:24]) + 9'(src_a);
  assign a_nxt = a_sum[8] ? 8'hFF : a_sum[7:0];

  always_ff @(posedge clk) begin
    if (rdy1) a1_r <= a_nxt;
    if (rdy2) a2_r <= a1_r;
    if (rdy3) a3_r <= a2_r;
    if (rdy4) a4_r <= a3_r;
  end

  apbm_chan u_chan_r (
    .clk  (clk),
    .ctl  (ctl),
    .mode (mode_r),
    .src  (src[23:16]),
    .dst  (dst[23:16]),
    .sa   (sa),
    .res  (res_r)
  );

  apbm_chan u_chan_g (
    .clk  (clk),
    .ctl  (ctl),
    .mode (mode_r),
    .src  (src[15:8]),
    .dst  (dst[15:8]),
    .sa   (sa),
    .res  (res_g)
  );

  apbm_chan u_chan_b (
    .clk  (clk),
    .ctl  (ctl),
    .mode (mode_r),
    .src  (src[7:0]),
    .dst  (dst[7:0]),
    .sa   (sa),
    .res  (res_b)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {a4_r, res_r, res_g, res_b};

endmodule
